// ===== hw/rtl/pngunf_pkg.sv =====
package pngunf_pkg;

    // Row filter codes carried in the first byte of every row
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BPP    = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PIXEL_W    = 32;

    typedef logic [PIXEL_W-1:0] t_pixel;

    // Operands for one sample reconstruction
    typedef struct packed {
        logic [2:0] filter;
        logic [7:0] raw;
        logic [7:0] left;
        logic [7:0] upper;
        logic [7:0] upper_left;
    } t_pred_req;

endpackage

// ===== hw/rtl/pngunf_line_store.sv =====
module pngunf_line_store #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = 12
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  pngunf_pkg::t_pixel     i_wr_data,
    input  logic                   i_rd_en,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output pngunf_pkg::t_pixel     o_rd_data
);

    pngunf_pkg::t_pixel r_mem [DEPTH];
    pngunf_pkg::t_pixel r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/pngunf_predictor.sv =====
module pngunf_predictor (
    input  pngunf_pkg::t_pred_req i_req,
    output logic [7:0]            o_sample
);

    logic signed [9:0] s_a;
    logic signed [9:0] s_b;
    logic signed [9:0] s_c;
    logic signed [9:0] d_pa;
    logic signed [9:0] d_pb;
    logic signed [9:0] d_pc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [8:0]        avg_sum;
    logic [7:0]        paeth;
    logic [7:0]        pred;

    assign s_a = signed'({2'b00, i_req.left});
    assign s_b = signed'({2'b00, i_req.upper});
    assign s_c = signed'({2'b00, i_req.upper_left});

    // p = a + b - c, so p - a = b - c, p - b = a - c, p - c = a + b - 2c
    assign d_pa = s_b - s_c;
    assign d_pb = s_a - s_c;
    assign d_pc = s_a + s_b - s_c - s_c;
    assign pa   = (d_pa < 0) ? 10'(-d_pa) : 10'(d_pa);
    assign pb   = (d_pb < 0) ? 10'(-d_pb) : 10'(d_pb);
    assign pc   = (d_pc < 0) ? 10'(-d_pc) : 10'(d_pc);

    always_comb begin
        priority if (pa <= pb && pa <= pc) begin
            paeth = i_req.left;
        end else if (pb <= pc) begin
            paeth = i_req.upper;
        end else begin
            paeth = i_req.upper_left;
        end
    end

    assign avg_sum = {1'b0, i_req.left} + {1'b0, i_req.upper};

    always_comb begin
        unique case (i_req.filter)
            pngunf_pkg::FILT_SUB:   pred = i_req.left;
            pngunf_pkg::FILT_UP:    pred = i_req.upper;
            pngunf_pkg::FILT_AVG:   pred = avg_sum[8:1];
            pngunf_pkg::FILT_PAETH: pred = paeth;
            default:                pred = 8'd0;
        endcase
    end

    assign o_sample = i_req.raw + pred;

endmodule

// ===== hw/rtl/png_scanline_unfilter_unit.sv =====
// Takes one byte per cycle with no bubbles while the result side keeps up.
// A pixel's result is in the output register in the cycle after its last sample byte is accepted.
// The line store read for the next column is issued with the current pixel, so its
// read latency stays hidden; the output register sets the only stall.
// Reset clears all control state and the registers (width 1, height 1, 3 bytes per pixel);
// the line store is not cleared, since row 0 never uses what it reads.
module png_scanline_unfilter_unit #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_wr_en,
    input  logic [1:0]                            i_cfg_index,
    input  logic [pngunf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // byte stream in
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [7:0]                            i_data_byte,
    input  logic                                  i_start_of_image,
    // pixel stream out
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [7:0]                            o_red,
    output logic [7:0]                            o_green,
    output logic [7:0]                            o_blue,
    output logic                                  o_status,
    output logic                                  o_end_of_row,
    output logic                                  o_end_of_image
);

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned LW = AW + 1;

    // Configuration registers
    logic [12:0] r_image_width;
    logic [15:0] r_image_height;
    logic [2:0]  r_bpp;

    // Row walk state
    logic [AW-1:0]          r_col,  n_col;
    logic [1:0]             r_chan, n_chan;
    logic [15:0]            r_row,  n_row;
    logic [2:0]             r_filter, n_filter;
    logic                   r_awaiting, n_awaiting;
    logic                   r_halted, n_halted;
    pngunf_pkg::t_pixel     r_cur,  n_cur;
    pngunf_pkg::t_pixel     r_left, n_left;
    pngunf_pkg::t_pixel     r_ul,   n_ul;

    // Output register
    logic                   r_out_valid;
    logic [7:0]             r_red, r_green, r_blue;
    logic                   r_status, r_eor, r_eoi;

    // Effective state once a start request is applied
    logic [AW-1:0]          col_e;
    logic [1:0]             chan_e;
    logic [15:0]            row_e;
    logic                   awaiting_e;
    logic                   halted_e;
    pngunf_pkg::t_pixel     cur_e, left_e, ul_e;

    logic                   accept;
    logic [LW-1:0]          eff_width;
    logic [15:0]            eff_height;
    logic                   last_chan;
    logic                   last_col;
    logic                   last_row;
    logic [LW-1:0]          col_inc;
    logic [4:0]             shamt;

    pngunf_pkg::t_pixel     rd_word;
    pngunf_pkg::t_pixel     up_word;
    pngunf_pkg::t_pixel     pix_word;
    pngunf_pkg::t_pred_req  pred_req;
    logic [7:0]             sample;

    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_rd_addr;

    logic                   res_valid;
    logic                   res_status;
    logic                   res_eor;
    logic                   res_eoi;
    logic [7:0]             res_red, res_green, res_blue;

    // Take a new request whenever the output register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Clamp the register values into their working ranges
    always_comb begin
        priority if (r_image_width == 13'd0) begin
            eff_width = LW'(1);
        end else if ({19'd0, r_image_width} > MAX_WIDTH) begin
            eff_width = LW'(MAX_WIDTH);
        end else begin
            eff_width = LW'(r_image_width);
        end
    end
    assign eff_height = (r_image_height == 16'd0) ? 16'd1 : r_image_height;

    // A start request restarts at row 0 and treats this byte as the filter byte
    assign awaiting_e = i_start_of_image ? 1'b1 : r_awaiting;
    assign halted_e   = i_start_of_image ? 1'b0 : r_halted;
    assign row_e      = i_start_of_image ? 16'd0 : r_row;
    assign col_e      = i_start_of_image ? '0 : r_col;
    assign chan_e     = i_start_of_image ? 2'd0 : r_chan;
    assign cur_e      = i_start_of_image ? '0 : r_cur;
    assign left_e     = i_start_of_image ? '0 : r_left;
    assign ul_e       = i_start_of_image ? '0 : r_ul;

    assign shamt      = {chan_e, 3'b000};
    assign last_chan  = (r_bpp >= 3'd4) ? (chan_e == 2'd3) : (chan_e >= 2'd2);
    assign col_inc    = {1'b0, col_e} + LW'(1);
    assign last_col   = col_inc >= eff_width;
    assign last_row   = ({1'b0, row_e} + 17'd1) >= {1'b0, eff_height};

    // Row 0 has nothing above it
    assign up_word    = (row_e != 16'd0) ? rd_word : '0;

    assign pred_req.filter     = r_filter;
    assign pred_req.raw        = i_data_byte;
    assign pred_req.left       = left_e[shamt +: 8];
    assign pred_req.upper      = up_word[shamt +: 8];
    assign pred_req.upper_left = ul_e[shamt +: 8];

    pngunf_predictor u_pred (
        .i_req    (pred_req),
        .o_sample (sample)
    );

    assign pix_word = cur_e | (pngunf_pkg::t_pixel'(sample) << shamt);

    always_comb begin
        n_col      = r_col;
        n_chan     = r_chan;
        n_row      = r_row;
        n_filter   = r_filter;
        n_awaiting = r_awaiting;
        n_halted   = r_halted;
        n_cur      = r_cur;
        n_left     = r_left;
        n_ul       = r_ul;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_rd_addr = '0;
        res_valid  = 1'b0;
        res_status = 1'b0;
        res_eor    = 1'b0;
        res_eoi    = 1'b0;
        res_red    = 8'd0;
        res_green  = 8'd0;
        res_blue   = 8'd0;

        if (accept) begin
            n_col      = col_e;
            n_chan     = chan_e;
            n_row      = row_e;
            n_awaiting = awaiting_e;
            n_halted   = halted_e;
            n_cur      = cur_e;
            n_left     = left_e;
            n_ul       = ul_e;

            if (!halted_e) begin
                if (awaiting_e) begin
                    if (i_data_byte > {5'd0, pngunf_pkg::FILT_PAETH}) begin
                        // Unknown filter: report once, then drop bytes until a start
                        n_halted   = 1'b1;
                        res_valid  = 1'b1;
                        res_status = 1'b1;
                    end else begin
                        n_filter    = i_data_byte[2:0];
                        n_awaiting  = 1'b0;
                        n_chan      = 2'd0;
                        n_cur       = '0;
                        // Fetch the upper pixel of column 0
                        mem_re      = 1'b1;
                        mem_rd_addr = '0;
                    end
                end else if (!last_chan) begin
                    n_cur  = pix_word;
                    n_chan = chan_e + 2'd1;
                end else begin
                    // Pixel complete: store it above the next row and report it
                    mem_we    = 1'b1;
                    n_ul      = up_word;
                    n_left    = pix_word;
                    res_valid = 1'b1;
                    res_red   = pix_word[7:0];
                    res_green = pix_word[15:8];
                    res_blue  = pix_word[23:16];
                    res_eor   = last_col;
                    res_eoi   = last_col && last_row;
                    n_chan    = 2'd0;
                    n_cur     = '0;
                    if (last_col) begin
                        n_row      = last_row ? 16'd0 : row_e + 16'd1;
                        n_col      = '0;
                        n_left     = '0;
                        n_ul       = '0;
                        n_awaiting = 1'b1;
                    end else begin
                        n_col       = col_inc[AW-1:0];
                        // Fetch the next column's upper pixel ahead of its first sample
                        mem_re      = 1'b1;
                        mem_rd_addr = col_inc[AW-1:0];
                    end
                end
            end
        end
    end

    pngunf_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (AW)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (col_e),
        .i_wr_data (pix_word),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (rd_word)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 13'd1;
            r_image_height <= 16'd1;
            r_bpp          <= 3'd3;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pngunf_pkg::CFG_WIDTH:  r_image_width  <= i_cfg_data[12:0];
                pngunf_pkg::CFG_HEIGHT: r_image_height <= i_cfg_data[15:0];
                pngunf_pkg::CFG_BPP:    r_bpp          <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // Row walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_chan     <= 2'd0;
            r_row      <= 16'd0;
            r_filter   <= pngunf_pkg::FILT_NONE;
            r_awaiting <= 1'b1;
            r_halted   <= 1'b0;
            r_cur      <= '0;
            r_left     <= '0;
            r_ul       <= '0;
        end else begin
            r_col      <= n_col;
            r_chan     <= n_chan;
            r_row      <= n_row;
            r_filter   <= n_filter;
            r_awaiting <= n_awaiting;
            r_halted   <= n_halted;
            r_cur      <= n_cur;
            r_left     <= n_left;
            r_ul       <= n_ul;
        end
    end

    // Output register: load a new result, else drop the one just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_red    <= res_red;
            r_green  <= res_green;
            r_blue   <= res_blue;
            r_status <= res_status;
            r_eor    <= res_eor;
            r_eoi    <= res_eoi;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_status       = r_status;
    assign o_end_of_row   = r_eor;
    assign o_end_of_image = r_eoi;

endmodule

// ===== tb/sv/png_scanline_unfilter_checker.sv =====
module png_scanline_unfilter_checker #(
    parameter int LINE_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [1:0]                        i_cfg_index,
    input  logic [pngunf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_start_of_image,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [7:0]                        i_red,
    input  logic [7:0]                        i_green,
    input  logic [7:0]                        i_blue,
    input  logic                              i_status,
    input  logic                              i_end_of_row,
    input  logic                              i_end_of_image,
    output int                                o_mismatches,
    output int                                o_outstanding
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       status;
        logic       end_of_row;
        logic       end_of_image;
    } t_exp_pixel;

    t_exp_pixel expected_pixels[$];
    t_exp_pixel oldest;

    logic [12:0] reg_width;
    logic [15:0] reg_height;
    logic [2:0]  reg_bpp;

    pngunf_pkg::t_pixel line_store [0:LINE_DEPTH-1];
    pngunf_pkg::t_pixel left_px;
    pngunf_pkg::t_pixel upleft_px;
    pngunf_pkg::t_pixel cur_px;
    logic [2:0]  cur_filter;
    int unsigned col;
    logic [1:0]  chan;
    logic [15:0] row_idx;
    bit          want_filter;
    bit          stopped;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, b, c);
        int p, pa, pb, pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    task automatic start_row();
        col         = 0;
        chan        = '0;
        cur_px      = '0;
        left_px     = '0;
        upleft_px   = '0;
        want_filter = 1'b1;
    endtask

    // Advance the unfilter state by one accepted byte; queue any pixel it completes
    task automatic unfilter_byte(input logic [7:0] data, input logic sof);
        int unsigned        width_eff, height_eff, bpp_eff, slot;
        pngunf_pkg::t_pixel above;
        logic [7:0]         a, b, c, pred, val;
        bit                 last_col, last_row;
        t_exp_pixel         px;

        width_eff  = (reg_width == 0) ? 1 : ((reg_width > LINE_DEPTH) ? LINE_DEPTH : reg_width);
        height_eff = (reg_height == 0) ? 1 : reg_height;
        bpp_eff    = (reg_bpp >= 4) ? 4 : 3;

        if (sof) begin
            stopped = 1'b0;
            row_idx = '0;
            start_row();
        end
        if (stopped)
            return;

        if (want_filter) begin
            if (data > pngunf_pkg::FILT_PAETH) begin
                stopped   = 1'b1;
                px        = '0;
                px.status = 1'b1;
                expected_pixels.push_back(px);
                return;
            end
            cur_filter  = data[2:0];
            want_filter = 1'b0;
            chan        = '0;
            cur_px      = '0;
            return;
        end

        slot  = (col < LINE_DEPTH) ? col : LINE_DEPTH - 1;
        above = (row_idx != 0) ? line_store[slot] : '0;
        a     = left_px[chan*8 +: 8];
        b     = above[chan*8 +: 8];
        c     = upleft_px[chan*8 +: 8];
        case (cur_filter)
            pngunf_pkg::FILT_SUB:   pred = a;
            pngunf_pkg::FILT_UP:    pred = b;
            pngunf_pkg::FILT_AVG:   pred = 8'((int'(a) + int'(b)) / 2);
            pngunf_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
            default:                pred = '0;
        endcase
        val = data + pred;
        cur_px[chan*8 +: 8] = val;

        if (chan + 1 < bpp_eff) begin
            chan++;
            return;
        end

        upleft_px        = above;
        line_store[slot] = cur_px;
        left_px          = cur_px;
        last_col         = (col + 1 >= width_eff);
        last_row         = (row_idx + 1 >= height_eff);

        px.red          = cur_px[7:0];
        px.green        = cur_px[15:8];
        px.blue         = cur_px[23:16];
        px.status       = 1'b0;
        px.end_of_row   = last_col;
        px.end_of_image = last_col && last_row;
        expected_pixels.push_back(px);

        if (last_col) begin
            row_idx = last_row ? '0 : row_idx + 1'b1;
            start_row();
        end else begin
            col++;
            chan   = '0;
            cur_px = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_width  = 13'd1;
            reg_height = 16'd1;
            reg_bpp    = 3'd3;
            cur_filter = pngunf_pkg::FILT_NONE;
            row_idx    = '0;
            stopped    = 1'b0;
            start_row();
            expected_pixels.delete();
        end else begin
            // Retire results first: a pixel leaving now never belongs to a byte arriving now
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected pixel: r=%02h g=%02h b=%02h st=%0b eor=%0b eoi=%0b",
                                 i_red, i_green, i_blue, i_status, i_end_of_row,
                                 i_end_of_image);
                end else begin
                    oldest = expected_pixels.pop_front();
                    if (i_red !== oldest.red || i_green !== oldest.green ||
                        i_blue !== oldest.blue || i_status !== oldest.status ||
                        i_end_of_row !== oldest.end_of_row ||
                        i_end_of_image !== oldest.end_of_image) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("pixel mismatch: expected r=%02h g=%02h b=%02h st=%0b ",
                                     oldest.red, oldest.green, oldest.blue, oldest.status,
                                     "eor=%0b eoi=%0b, ",
                                     oldest.end_of_row, oldest.end_of_image,
                                     "got r=%02h g=%02h b=%02h st=%0b eor=%0b eoi=%0b",
                                     i_red, i_green, i_blue, i_status, i_end_of_row,
                                     i_end_of_image);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                unfilter_byte(i_data_byte, i_start_of_image);
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    pngunf_pkg::CFG_WIDTH:  reg_width  = i_cfg_data[12:0];
                    pngunf_pkg::CFG_HEIGHT: reg_height = i_cfg_data[15:0];
                    pngunf_pkg::CFG_BPP:    reg_bpp    = i_cfg_data[2:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = expected_pixels.size();
    end

endmodule

// ===== tb/sv/png_scanline_unfilter_unit_tb.sv =====
module png_scanline_unfilter_unit_tb;

    // Lowest filter byte that the block must reject
    localparam logic [7:0] BAD_FILTER_MIN = 8'd5;
    // Cycles without any handshake or register write before the run is abandoned
    localparam int STALL_LIMIT = 5000;

    logic                              i_clk            = 1'b0;
    logic                              i_rst_n          = 1'b0;
    logic                              i_cfg_wr_en      = 1'b0;
    logic [1:0]                        i_cfg_index      = pngunf_pkg::CFG_WIDTH;
    logic [pngunf_pkg::CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                              i_in_valid       = 1'b0;
    logic                              o_in_ready;
    logic [7:0]                        i_data_byte      = '0;
    logic                              i_start_of_image = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_ready      = 1'b0;
    logic [7:0]                        o_red;
    logic [7:0]                        o_green;
    logic [7:0]                        o_blue;
    logic                              o_status;
    logic                              o_end_of_row;
    logic                              o_end_of_image;

    int mismatches;
    int outstanding;

    // Stimulus bookkeeping: geometry as the block will apply it, and traffic shaping
    int unsigned cur_w, cur_h, cur_bpp;
    bit          need_start;
    int          items_sent;
    int          send_gap_pct;
    int          recv_gap_pct;
    int          quiet_cycles;

    png_scanline_unfilter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_start_of_image (i_start_of_image),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_status         (o_status),
        .o_end_of_row     (o_end_of_row),
        .o_end_of_image   (o_end_of_image)
    );

    png_scanline_unfilter_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_start_of_image (i_start_of_image),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_red            (o_red),
        .i_green          (o_green),
        .i_blue           (o_blue),
        .i_status         (o_status),
        .i_end_of_row     (o_end_of_row),
        .i_end_of_image   (o_end_of_image),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    always #10 i_clk = ~i_clk;

    // Stall the pixel side at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Abort if the channels stop moving for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, idling first at the phase's rate, and hold it until accepted.
    // Called right after an edge; leaves valid high so the next request can follow
    // back to back.
    task automatic send_byte(input logic [7:0] value, input logic sof);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= value;
        i_start_of_image <= sof;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid, wait for every predicted pixel, then let the last filter byte settle
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write all three registers while the block is idle. The next image must open
    // with a start so that no row above is read at a column it never wrote.
    task automatic program_geometry(input logic [15:0] w, input logic [15:0] h,
                                    input logic [15:0] bpp);
        drain_pipeline();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= pngunf_pkg::CFG_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= pngunf_pkg::CFG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_index <= pngunf_pkg::CFG_BPP;
        i_cfg_data  <= bpp;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_w      = (w[12:0] == 0) ? 1 : ((w[12:0] > 4096) ? 4096 : w[12:0]);
        cur_h      = (h == 0) ? 1 : h;
        cur_bpp    = (bpp[2:0] >= 4) ? 4 : 3;
        need_start = 1'b1;
    endtask

    // Stream one image with random filters and samples; a nonzero cut stops after
    // that many bytes
    task automatic stream_image(input int cut);
        int  stop_at;
        logic sof;
        stop_at    = (cut == 0) ? -1 : items_sent + cut;
        sof        = need_start ? 1'b1 : 1'($urandom_range(1));
        need_start = 1'b0;
        for (int r = 0; r < cur_h; r++) begin
            send_byte(8'($urandom_range(pngunf_pkg::FILT_PAETH)), sof);
            sof = 1'b0;
            items_sent++;
            if (items_sent == stop_at)
                return;
            for (int k = 0; k < cur_w * cur_bpp; k++) begin
                send_byte(8'($urandom), 1'b0);
                items_sent++;
                if (items_sent == stop_at)
                    return;
            end
        end
    endtask

    // Mostly whole small images; some rejected filter bytes with ignored trailing
    // noise, and some images cut short
    task automatic random_traffic(input int quota);
        int goal;
        int roll;
        int image_bytes;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            if ($urandom_range(99) < 35)
                program_geometry({3'($urandom), 13'($urandom_range(4))},
                                 16'($urandom_range(3)),
                                 {13'($urandom), 3'($urandom_range(7))});
            roll        = $urandom_range(99);
            image_bytes = cur_h * (1 + cur_w * cur_bpp);
            if (roll < 10) begin
                send_byte(8'($urandom_range(255, BAD_FILTER_MIN)),
                          need_start ? 1'b1 : 1'($urandom_range(1)));
                items_sent++;
                repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
                need_start = 1'b1;
            end else if (roll < 20) begin
                stream_image($urandom_range(image_bytes - 1, 1));
                need_start = 1'b1;
            end else begin
                stream_image(0);
            end
        end
    endtask

    initial begin
        cur_w        = 1;
        cur_h        = 1;
        cur_bpp      = 3;
        need_start   = 1'b1;
        items_sent   = 0;
        send_gap_pct = 20;
        recv_gap_pct = 79;

        // Hold reset at the start, then release it for good
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: one RGB pixel, unfiltered, extreme sample values
        send_byte(8'(pngunf_pkg::FILT_NONE), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // Image wrapped to row 0: reject a bad filter, ignore the byte after it,
        // then reject the largest byte arriving with a start
        send_byte(BAD_FILTER_MIN, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Two pixels by four rows, one row per filter; samples wrap past 255
        program_geometry(16'd2, 16'd4, 16'd3);
        send_byte(8'(pngunf_pkg::FILT_SUB), 1'b1);
        send_byte(8'h10, 1'b0); send_byte(8'h20, 1'b0); send_byte(8'h30, 1'b0);
        send_byte(8'hF0, 1'b0); send_byte(8'hE0, 1'b0); send_byte(8'hD0, 1'b0);
        send_byte(8'(pngunf_pkg::FILT_UP), 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'(pngunf_pkg::FILT_AVG), 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFE, 1'b0); send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b0); send_byte(8'h04, 1'b0);
        send_byte(8'(pngunf_pkg::FILT_PAETH), 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'h00, 1'b0);

        random_traffic(90);

        // Swap the idling: sender sparse, receiver mostly ready
        send_gap_pct = 79;
        recv_gap_pct = 20;
        random_traffic(90);

        // No idling on either side
        send_gap_pct = 0;
        recv_gap_pct = 0;
        random_traffic(90);

        // Widest rows in RGBA: run the start of row 0 only
        program_geometry(16'h1000, 16'd2, 16'd4);
        stream_image(40);
        // Width beyond the line store clamps to it; height zero acts as one row
        program_geometry(16'hFFFF, 16'h0000, 16'hFFFB);
        stream_image(30);
        // Tallest image: run three rows, never reaching the final pixel
        program_geometry(16'h0002, 16'hFFFF, 16'h0003);
        stream_image(3 * (1 + 2 * 3));

        drain_pipeline();
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
